/* rtl/sdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 32;
    localparam int unsigned DIGITS_MAX    = 10;

    localparam logic [6:0]  CH_ZERO  = 7'd48;
    localparam logic [6:0]  CH_MINUS = 7'd45;

    // ceil(2^35 / 10): q = (a * RECIP_10) >> 35 is exact for every 32-bit a
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SH = 35;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_SIGN,
        S_PAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  rem;
    } t_div_res;

endpackage

/* rtl/sdf_div10.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_div10
// Divide-by-ten unit: registered reciprocal multiply, then quotient and
// remainder from the registered product.
// ----------------------------------------------------------------------------
module sdf_div10
    import sdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_dividend,
    output t_div_res    o_res
);

    logic [63:0] r_prod;
    logic [31:0] r_dividend;
    logic [31:0] quot;
    logic [31:0] times10;
    logic [31:0] diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= {32'd0, i_dividend} * {32'd0, RECIP_10};
            r_dividend <= i_dividend;
        end
    end

    always_comb begin
        quot      = 32'(r_prod >> RECIP_SH);
        // q * 10 as shift-and-add
        times10   = (quot << 3) + (quot << 1);
        diff      = r_dividend - times10;
        o_res.quot = quot;
        o_res.rem  = diff[3:0];
    end

endmodule

/* rtl/signed_decimal_formatter_unit.sv */
`timescale 1ns / 1ps
// Sequence: for each of the D decimal digits (1..10), a multiply state (S_MUL) and a
//   digit state (S_DIG) on the divider; then sign, padding and digits are emitted.
// Characters: N = max of text length and saturated width, one character per cycle;
//   N is at most max(11, MAX_WIDTH), 32 by default; a new start is taken only in idle.
// Reset: synchronous, active low; returns the sequencer to idle, drops o_valid.
// Results are strobed on o_valid for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// signed_decimal_formatter_unit
// Formats a signed 32-bit value as zero-padded decimal ASCII, one character
// per cycle, using a shared divide-by-ten unit under a small sequencer.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_unit
    import sdf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_min_width,
    output logic        busy,
    output logic        o_valid,
    output logic [6:0]  o_char_out,
    output logic        o_last_char
);

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WW = (CW > 6) ? CW : 6;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

    t_state       r_state, n_state;
    logic         r_neg, n_neg;
    logic [31:0]  r_mag, n_mag;
    logic [WW-1:0] r_width, n_width;
    logic [WW-1:0] r_pad, n_pad;
    logic [3:0]   r_ndig, n_ndig;
    logic [3:0]   r_digits [DIGITS_MAX];
    logic         r_valid, n_valid;
    logic [6:0]   r_char, n_char;
    logic         r_last, n_last;

    logic         accept;
    logic         div_en;
    t_div_res     div_res;
    logic [WW-1:0] width_ext;
    logic [WW-1:0] text_len;
    logic [WW-1:0] pad_calc;
    logic [3:0]   emit_idx;
    logic         dig_done;

    sdf_div10 u_div10 (
        .i_clk      (i_clk),
        .i_en       (div_en),
        .i_dividend (r_mag),
        .o_res      (div_res)
    );

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign div_en   = (r_state == S_MUL);
    assign dig_done = (div_res.quot == 32'd0) || (r_ndig == 4'(DIGITS_MAX - 1));
    assign emit_idx = r_ndig - 4'd1;

    // text length after this digit: digits so far plus this one plus sign
    assign width_ext = WW'(i_min_width);
    assign text_len  = WW'(r_ndig) + WW'(1) + WW'(r_neg);
    assign pad_calc  = (r_width > text_len) ? (r_width - text_len) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_MUL;
            end
            S_MUL:  n_state = S_DIG;
            S_DIG: begin
                if (!dig_done)             n_state = S_MUL;
                else if (r_neg)            n_state = S_SIGN;
                else if (pad_calc != '0)   n_state = S_PAD;
                else                       n_state = S_EMIT;
            end
            S_SIGN: begin
                n_state = (r_pad != '0) ? S_PAD : S_EMIT;
            end
            S_PAD: begin
                if (r_pad == WW'(1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_ndig == 4'd1) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_width = r_width;
        n_pad   = r_pad;
        n_ndig  = r_ndig;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = i_value[31];
                    n_mag   = i_value[31] ? (32'd0 - i_value) : i_value;
                    n_width = (width_ext > MAX_W) ? MAX_W : width_ext;
                    n_ndig  = 4'd0;
                end
            end
            S_DIG: begin
                n_mag  = div_res.quot;
                n_ndig = r_ndig + 4'd1;
                n_pad  = pad_calc;
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = CH_MINUS;
            end
            S_PAD: begin
                n_valid = 1'b1;
                n_char  = CH_ZERO;
                n_pad   = r_pad - WW'(1);
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_char  = CH_ZERO + {3'd0, r_digits[emit_idx]};
                n_last  = (r_ndig == 4'd1);
                n_ndig  = r_ndig - 4'd1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_width <= n_width;
        r_pad   <= n_pad;
        r_ndig  <= n_ndig;
        r_char  <= n_char;
        r_last  <= n_last;
        if (r_state == S_DIG) begin
            r_digits[r_ndig] <= div_res.rem;
        end
    end

    assign o_valid     = r_valid;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

    // the last character always closes the transaction
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |-> (r_state == S_IDLE))
        else $error("last character strobed while sequencer still busy");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_SIGN || r_state == S_PAD || r_state == S_EMIT))
        else $error("character strobed outside an emitting state");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_MUL))
        else $error("accepted transaction did not start digit extraction");

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ndig != 4'd0 && r_ndig <= 4'(DIGITS_MAX)))
        else $error("digit count out of range while emitting");

    a_rem_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (div_res.rem <= 4'd9))
        else $error("divider remainder is not a decimal digit");

endmodule
